/* rtl/cba_pkg.sv */
`timescale 1ns / 1ps
package cba_pkg;

  localparam int MAX_CLUSTERS = 4096;
  localparam int WORD_BITS    = 64;
  localparam int MAP_WORDS    = (MAX_CLUSTERS + WORD_BITS - 1) / WORD_BITS;
  localparam int IDX_W        = $clog2(MAX_CLUSTERS);
  localparam int BIT_W        = $clog2(WORD_BITS);
  localparam int WADDR_W      = $clog2(MAP_WORDS);
  localparam int CN_W         = 13;
  localparam int FIRST_DATA   = 2;

  typedef logic [CN_W-1:0] cn_t;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLEAN = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BADFREE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_FREE_WAIT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_issue;
    logic free_read;
    logic free_write;
    logic alloc_write;
    logic clean;
    logic mark_nospace;
    logic mark_badfree;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic is_free;
    logic is_clean;
    logic count_zero;
    logic free_bad;
    logic found;
    logic exhausted;
    logic out_free;
  } sts_t;

endpackage

/* rtl/cba_ctrl.sv */
`timescale 1ns / 1ps
module cba_ctrl
  import cba_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (sts.is_alloc) begin
          state_nxt = sts.count_zero ? S_RESP : S_SCAN;
        end else if (sts.is_free) begin
          state_nxt = sts.free_bad ? S_RESP : S_FREE_WAIT;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_SCAN: begin
        if (sts.found || sts.exhausted) state_nxt = S_RESP;
      end
      S_FREE_WAIT: state_nxt = S_RESP;
      S_RESP: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_DECODE: begin
        if (sts.is_alloc) begin
          cmd.mark_nospace = sts.count_zero;
          cmd.scan_start   = !sts.count_zero;
        end else if (sts.is_free) begin
          cmd.mark_badfree = sts.free_bad;
          cmd.free_read    = !sts.free_bad;
        end else begin
          cmd.clean = sts.is_clean;
        end
      end
      S_SCAN: begin
        cmd.scan_issue   = 1'b1;
        cmd.alloc_write  = sts.found;
        cmd.mark_nospace = sts.exhausted;
      end
      S_FREE_WAIT: cmd.free_write = 1'b1;
      S_RESP:      cmd.out_load   = sts.out_free;
      default: ;
    endcase
  end

endmodule

/* rtl/cba_dp.sv */
`timescale 1ns / 1ps
module cba_dp
  import cba_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [CN_W-1:0]           cfg_wr_data,
  input  logic [1:0]                in_op,
  input  cn_t                       in_cn,
  input  cmd_t                      cmd,
  output sts_t                      sts,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [CN_W+2:0]           out_data
);

  // configuration and request
  logic [CN_W-1:0]      count_r;
  logic [1:0]           op_r;
  cn_t                  cn_r;
  logic [CN_W-1:0]      live_n;
  logic [CN_W-1:0]      nm1;
  logic [CN_W-1:0]      cn_off;
  logic                 in_rng;
  logic [IDX_W-1:0]     hint_idx;
  logic [WADDR_W-1:0]   hw;
  logic [BIT_W-1:0]     hb;
  logic [WADDR_W-1:0]   lastw;
  logic [BIT_W:0]       nb;

  // bitmap store
  logic [WORD_BITS-1:0] mem_r [MAP_WORDS];
  logic [MAP_WORDS-1:0] row_vld_r;
  logic [WORD_BITS-1:0] rd_data_r;
  logic                 rd_row_ok_r;

  // scan pipeline
  logic [WADDR_W-1:0]   iss_word_r;
  logic                 iss_wrap_r;
  logic                 iss_act_r;
  logic                 rd_en;
  logic [WADDR_W-1:0]   rd_addr;
  logic                 rd_vld_r;
  logic [WADDR_W-1:0]   rd_word_r;
  logic                 rd_wrap_r;
  logic                 rd_last_r;

  logic [WORD_BITS-1:0] word_q;
  logic [BIT_W-1:0]     lo_b;
  logic [BIT_W:0]       hi_b;
  logic [WORD_BITS:0]   hi_full;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] cand;
  logic [WORD_BITS-1:0] lowest;
  logic [BIT_W-1:0]     fbit;
  logic                 wr_en;
  logic [WORD_BITS-1:0] wr_data;

  // result
  cn_t                  res_cluster_r;
  status_t              res_status_r;
  logic                 dirty_r;
  logic                 out_tvalid_r;
  logic [CN_W+2:0]      out_data_r;

  always_comb begin
    live_n   = (count_r > CN_W'(MAX_CLUSTERS)) ? CN_W'(MAX_CLUSTERS) : count_r;
    nm1      = live_n - CN_W'(1);
    cn_off   = cn_r - CN_W'(FIRST_DATA);
    in_rng   = (cn_r >= CN_W'(FIRST_DATA)) && (cn_off < live_n);
    hint_idx = in_rng ? cn_off[IDX_W-1:0] : '0;
    hw       = hint_idx[IDX_W-1:BIT_W];
    hb       = hint_idx[BIT_W-1:0];
    lastw    = nm1[IDX_W-1:BIT_W];
    nb       = {1'b0, nm1[BIT_W-1:0]} + (BIT_W+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CN_W'(MAX_CLUSTERS);
    end else if (cfg_wr_en) begin
      count_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_op;
      cn_r <= in_cn;
    end
  end

  // issue pointer: first pass hint word to last word, then wrap from word 0 to hint word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_act_r <= 1'b0;
    end else if (cmd.scan_start) begin
      iss_act_r <= 1'b1;
    end else if (cmd.scan_issue && iss_act_r && iss_wrap_r && iss_word_r == hw) begin
      iss_act_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      iss_word_r <= hw;
      iss_wrap_r <= 1'b0;
    end else if (cmd.scan_issue && iss_act_r) begin
      if (!iss_wrap_r && iss_word_r == lastw) begin
        iss_word_r <= '0;
        iss_wrap_r <= 1'b1;
      end else begin
        iss_word_r <= iss_word_r + WADDR_W'(1);
      end
    end
  end

  assign rd_en   = cmd.free_read || (cmd.scan_issue && iss_act_r);
  assign rd_addr = cmd.free_read ? hw : iss_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_issue && iss_act_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r   <= mem_r[rd_addr];
      rd_row_ok_r <= row_vld_r[rd_addr];
      rd_word_r   <= rd_addr;
      rd_wrap_r   <= iss_wrap_r;
      rd_last_r   <= iss_wrap_r && (iss_word_r == hw);
    end
  end

  // a row never written since reset reads as all free
  assign word_q = rd_row_ok_r ? rd_data_r : '0;

  always_comb begin
    lo_b = (!rd_wrap_r && rd_word_r == hw) ? hb : '0;
    if (rd_wrap_r) begin
      hi_b = (rd_word_r == hw) ? {1'b0, hb} : (BIT_W+1)'(WORD_BITS);
    end else begin
      hi_b = (rd_word_r == lastw) ? nb : (BIT_W+1)'(WORD_BITS);
    end
    hi_full = ~({(WORD_BITS+1){1'b1}} << hi_b);
    mask    = ({WORD_BITS{1'b1}} << lo_b) & hi_full[WORD_BITS-1:0];
    cand    = ~word_q & mask;
    lowest  = cand & (~cand + WORD_BITS'(1));
    fbit    = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (lowest[i]) fbit = fbit | BIT_W'(i);
    end
  end

  assign wr_en   = cmd.alloc_write || cmd.free_write;
  assign wr_data = cmd.alloc_write ? (word_q | lowest)
                                   : (word_q & ~(WORD_BITS'(1) << hb));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[rd_word_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (wr_en) begin
      row_vld_r[rd_word_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dirty_r <= 1'b0;
    end else if (wr_en) begin
      dirty_r <= 1'b1;
    end else if (cmd.clean) begin
      dirty_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_cluster_r <= '0;
      res_status_r  <= ST_OK;
    end else if (cmd.alloc_write) begin
      res_cluster_r <= CN_W'({rd_word_r, fbit}) + CN_W'(FIRST_DATA);
    end else if (cmd.mark_nospace) begin
      res_status_r <= ST_NOSPACE;
    end else if (cmd.mark_badfree) begin
      res_status_r <= ST_BADFREE;
    end
  end

  // output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {dirty_r, res_status_r, res_cluster_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_data   = out_data_r;

  always_comb begin
    sts            = '0;
    sts.is_alloc   = (op_r == OP_ALLOC);
    sts.is_free    = (op_r == OP_FREE);
    sts.is_clean   = (op_r == OP_CLEAN);
    sts.count_zero = (live_n == '0);
    sts.free_bad   = !in_rng;
    sts.found      = rd_vld_r && (cand != '0);
    sts.exhausted  = rd_vld_r && rd_last_r && (cand == '0);
    sts.out_free   = !out_tvalid_r || out_tready;
  end

`ifndef SYNTHESIS
  a_fail_no_cluster: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && res_status_r != ST_OK) |-> (res_cluster_r == '0))
    else $error("failed request carries a cluster number");

  a_grant_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc_write |-> (CN_W'({rd_word_r, fbit}) < live_n))
    else $error("granted bit beyond cluster count");

  a_write_dirty: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> dirty_r)
    else $error("bitmap changed without dirty mark");

  a_wrap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_vld_r && rd_wrap_r) |-> (rd_word_r <= hw))
    else $error("wrap pass read past hint word");
`endif

endmodule

/* rtl/cluster_bitmap_allocator.sv */
`timescale 1ns / 1ps
// Clean, unused-op and rejected requests go from decode straight to the response state, a free
// passes through a write-back state; an allocate scans the bitmap, reading up to 65 words.
// One request is handled at a time; the next can be taken in the cycle after the result is loaded.
// The scan reads one 64-bit word per cycle; a grant is written back as the next read issues.
// Reset (rst_n, synchronous, active low) frees every cluster at once through per-word valid
// bits, clears the dirty mark and sets the cluster count to 4096.
module cluster_bitmap_allocator
  import cba_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  logic [CN_W-1:0] cfg_wr_data,    // cluster_count
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [15:0]     in_tdata,       // [12:0] cluster_number
  input  logic [1:0]      in_tuser,       // [1:0] op
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [15:0]     out_tdata       // [12:0] allocated_cluster, [14:13] status, [15] map_dirty
);

  cmd_t cmd;
  sts_t sts;

  cba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cba_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_op       (in_tuser),
    .in_cn       (in_tdata[CN_W-1:0]),
    .cmd         (cmd),
    .sts         (sts),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_data    (out_tdata)
  );

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
module tb
  import cba_pkg::*;
();

  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Same layout as out_tdata: cluster lowest, then status, then dirty mark.
  typedef struct packed {
    logic    map_dirty;
    status_t status;
    cn_t     cluster;
  } alloc_result_t;

  class alloc_scoreboard;
    bit            usage [MAX_CLUSTERS];
    bit            dirty;
    int unsigned   count_reg;
    alloc_result_t expected_q[$];
    cn_t           granted_q[$];
    int unsigned   mismatches;

    function void restart();
      foreach (usage[i]) usage[i] = 1'b0;
      dirty = 1'b0;
      count_reg = 4096;
      expected_q.delete();
      granted_q.delete();
      mismatches = 0;
    endfunction

    function void set_count(cn_t v);
      count_reg = v;
    endfunction

    function int unsigned pending_results();
      return expected_q.size();
    endfunction

    // Lowest clear bit in [lo, hi); claim it.
    function bit take_lowest_free(int unsigned lo, int unsigned hi,
                                  output int unsigned idx);
      idx = 0;
      for (int unsigned i = lo; i < hi; i++) begin
        if (!usage[i]) begin
          usage[i] = 1'b1;
          idx = i;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_request(logic [1:0] op, cn_t cn);
      int unsigned   t;
      int unsigned   c;
      int unsigned   start;
      int unsigned   idx;
      bit            ok;
      alloc_result_t r;
      t = (count_reg > MAX_CLUSTERS) ? MAX_CLUSTERS : count_reg;
      c = cn;
      r.cluster = '0;
      r.status  = ST_OK;
      case (op)
        OP_ALLOC: begin
          start = (c >= FIRST_DATA && c - FIRST_DATA < t) ? c - FIRST_DATA : 0;
          ok = take_lowest_free(start, t, idx);
          if (!ok) ok = take_lowest_free(0, start, idx);
          if (ok) begin
            r.cluster = cn_t'(idx + FIRST_DATA);
            dirty = 1'b1;
            granted_q.push_back(r.cluster);
          end else begin
            r.status = ST_NOSPACE;
          end
        end
        OP_FREE: begin
          if (c < FIRST_DATA || c - FIRST_DATA >= t) begin
            r.status = ST_BADFREE;
          end else begin
            usage[c - FIRST_DATA] = 1'b0;
            dirty = 1'b1;
          end
        end
        OP_CLEAN: dirty = 1'b0;
        default: ;
      endcase
      r.map_dirty = dirty;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [15:0] data);
      alloc_result_t got;
      alloc_result_t want;
      got = alloc_result_t'(data);
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result with no request pending: %h", $realtime, data);
        return;
      end
      want = expected_q.pop_front();
      if (got.cluster !== want.cluster || got.status !== want.status ||
          got.map_dirty !== want.map_dirty) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"[%0t] mismatch: cluster exp %0d got %0d, ",
                    "status exp %0d got %0d, dirty exp %0d got %0d"},
                   $realtime, want.cluster, got.cluster, want.status, got.status,
                   want.map_dirty, got.map_dirty);
      end
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            cfg_wr_en = 1'b0;
  logic [CN_W-1:0] cfg_wr_data = '0;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic [15:0]     in_tdata = '0;
  logic [1:0]      in_tuser = '0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [15:0]     out_tdata;

  bit              idle_on = 1'b1;
  int unsigned     hold_cycles = 0;
  alloc_scoreboard sb = new();

  cluster_bitmap_allocator u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Check the result first: a request taken at this edge cannot answer at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if (in_tvalid && in_tready) sb.note_request(in_tuser, cn_t'(in_tdata[CN_W-1:0]));
    end
  end

  // Receiver: long hold-off when asked, otherwise short random stall bursts when idle_on is set.
  initial begin
    int unsigned burst;
    burst = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_cycles != 0) begin
        out_tready = 1'b0;
        hold_cycles--;
      end else if (burst != 0) begin
        out_tready = 1'b0;
        burst--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_tready = 1'b0;
        burst = $urandom_range(0, 3);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic issue_request(logic [1:0] op, cn_t cn);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {3'b000, cn};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_tvalid = 1'b0;
    while (sb.pending_results() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cluster_count(cn_t v);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    sb.set_count(v);
  endtask

  task automatic run_random_phase(cn_t count, int unsigned items, bit idling, bit long_hold);
    logic [1:0]  op;
    cn_t         cn;
    int unsigned t;
    int unsigned sel;
    int unsigned kind;
    int unsigned j;
    wait_for_results();
    write_cluster_count(count);
    idle_on = idling;
    // Receiver sits out a long stretch while requests keep coming.
    if (long_hold) hold_cycles = 300;
    t = (count > MAX_CLUSTERS) ? MAX_CLUSTERS : count;
    for (int unsigned n = 0; n < items; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 48)      op = OP_ALLOC;
      else if (sel < 83) op = OP_FREE;
      else if (sel < 92) op = OP_CLEAN;
      else               op = OP_UNUSED;
      kind = $urandom_range(0, 9);
      if (op == OP_FREE && kind < 5 && sb.granted_q.size() != 0) begin
        // free something handed out earlier
        j = $urandom_range(0, sb.granted_q.size() - 1);
        cn = sb.granted_q[j];
        sb.granted_q.delete(j);
      end else if (kind < 7 && t != 0) begin
        cn = cn_t'($urandom_range(FIRST_DATA, t + FIRST_DATA - 1));
      end else if (kind < 8) begin
        case ($urandom_range(0, 3))
          0:       cn = cn_t'(0);
          1:       cn = cn_t'(1);
          2:       cn = cn_t'(t + 1);
          default: cn = cn_t'(t + 2);
        endcase
      end else begin
        cn = cn_t'($urandom_range(0, 8191));
      end
      issue_request(op, cn);
      if ($urandom_range(0, 99) == 0) wait_for_results();
    end
  endtask

  initial begin
    int unsigned ph_count [13];
    int unsigned ph_items [13];
    ph_count = '{64, 65, 3, 130, 8191, 0, 1, 5000, 127, 128, 2000, 10, 4096};
    ph_items = '{100, 100, 60, 100, 90, 40, 50, 90, 100, 100, 100, 80, 200};
    sb.restart();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Full map: hint edges, wraparound, bad and repeated frees, clean, unused op.
    issue_request(OP_ALLOC, 0);
    issue_request(OP_ALLOC, 1);
    issue_request(OP_ALLOC, 2);
    issue_request(OP_ALLOC, 4097);
    issue_request(OP_ALLOC, 4097);
    issue_request(OP_ALLOC, 4098);
    issue_request(OP_ALLOC, 8191);
    issue_request(OP_FREE, 5);
    issue_request(OP_FREE, 5);
    issue_request(OP_FREE, 0);
    issue_request(OP_FREE, 1);
    issue_request(OP_FREE, 4098);
    issue_request(OP_FREE, 8191);
    issue_request(OP_FREE, 4097);
    issue_request(OP_CLEAN, 0);
    issue_request(OP_UNUSED, 8191);
    issue_request(OP_FREE, 1);
    issue_request(OP_ALLOC, 3000);
    // No clusters tracked.
    wait_for_results();
    write_cluster_count(0);
    issue_request(OP_ALLOC, 2);
    issue_request(OP_FREE, 2);
    issue_request(OP_CLEAN, 8191);
    // One cluster tracked.
    wait_for_results();
    write_cluster_count(1);
    issue_request(OP_FREE, 2);
    issue_request(OP_ALLOC, 5);
    issue_request(OP_ALLOC, 2);
    // Count above capacity.
    wait_for_results();
    write_cluster_count(8191);
    issue_request(OP_ALLOC, 4097);
    issue_request(OP_FREE, 4098);

    for (int i = 0; i < 13; i++)
      run_random_phase(cn_t'(ph_count[i]), ph_items[i], i != 12, i == 0);

    wait_for_results();
    repeat (80) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending_results() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("== FAIL ==");
    $finish;
  end
endmodule
